[rtl/cartridge_bank_controller_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the cartridge bank controller
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbc: next-cycle check failed");

`endif

[rtl/cbc_pkg.sv]
// ---------------------------------------------------------------------------
// Cartridge bank controller package
// Beat types, controller kinds, address areas and mapping helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbc_pkg;

	// default ROM bank limit
	localparam int unsigned MAX_ROM_BANKS_DEF = 512;

	// config register indexes
	typedef enum logic [1:0] {
		REG_HEADER_TYPE    = 2'd0,
		REG_ROM_BANK_MASK  = 2'd1,
		REG_RAM_BANK_MASK  = 2'd2,
		REG_MULTICART_MODE = 2'd3
	} reg_idx_e;

	// controller kinds
	typedef enum logic [2:0] {
		KIND_PLAIN = 3'd0,
		KIND_MBC1  = 3'd1,
		KIND_MBC2  = 3'd2,
		KIND_MBC3  = 3'd3,
		KIND_MBC5  = 3'd4
	} kind_e;

	// register areas, write address bits 14:13
	typedef enum logic [1:0] {
		AREA_RAM_EN   = 2'd0,
		AREA_ROM_BANK = 2'd1,
		AREA_RAM_BANK = 2'd2,
		AREA_MODE     = 2'd3
	} area_e;

	typedef struct packed {
		logic [14:0] write_addr;
		logic [7:0]  write_data;
	} wr_beat_t;

	typedef struct packed {
		logic [5:0] low_rom_bank;
		logic [8:0] high_rom_bank;
		logic [3:0] ram_bank_sel;
		logic       ram_on;
	} map_beat_t;

	// header type (plus one, mod 32) to controller kind
	function automatic kind_e kind_lookup(input logic [4:0] idx);
		kind_e k;
		case (idx)
			5'd0, 5'd2, 5'd3, 5'd4:               k = KIND_MBC1;
			5'd6, 5'd7:                           k = KIND_MBC2;
			5'd16, 5'd17, 5'd18, 5'd19, 5'd20:    k = KIND_MBC3;
			5'd26, 5'd27, 5'd28, 5'd29, 5'd30,
			5'd31:                                k = KIND_MBC5;
			default:                              k = KIND_PLAIN;
		endcase
		return k;
	endfunction

	// steer away from bank zero (MBC1 per 32-bank group, MBC5 only bank 0)
	function automatic logic [8:0] fix_zero_bank(input logic [8:0] bank, input kind_e kind);
		logic bump;
		bump = ((kind == KIND_MBC1) && (bank[4:0] == 5'd0)) ||
		       ((kind == KIND_MBC5) && (bank == 9'd0));
		return bank + {8'd0, bump};
	endfunction

	// multicart remap: bits 6:5 move to 5:4, bit 4 dropped
	function automatic logic [5:0] multi_remap(input logic [8:0] bank);
		return {bank[6:5], bank[3:0]};
	endfunction

endpackage

[rtl/cartridge_bank_controller_core.sv]
// Cartridge bank controller. Each write beat (address and data byte) passes an
// input register, then updates the bank and mode registers and the mapping; the
// resulting mapping beat (lower and upper ROM bank, RAM bank, RAM enable) sits
// in an output register. One beat is taken every cycle while the output side
// keeps up; between a write and its mapping beat lie the input register and the
// output register, and a stall on the output side holds the beat in the input
// register. The header type, ROM and RAM masks and multicart mode are set through
// the APB port and also act on a beat already in the input register; write them
// while no beat is in flight.
// ---------------------------------------------------------------------------
// Cartridge bank controller core
// Bank/mode registers and mapping for plain, MBC1, MBC2, MBC3, MBC5 carts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_bank_controller_core #(
	parameter int unsigned MAX_ROM_BANKS = cbc_pkg::MAX_ROM_BANKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// write beats
	input  logic               wr_valid,
	output logic               wr_stall,
	input  cbc_pkg::wr_beat_t  wr_beat,
	// mapping beats
	output logic               map_valid,
	input  logic               map_stall,
	output cbc_pkg::map_beat_t map_beat,
	// APB config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [8:0] RomMaskLimit = 9'(MAX_ROM_BANKS - 1);

	// config registers
	logic [7:0] header_type_q;
	logic [8:0] rom_bank_mask_q;
	logic [3:0] ram_bank_mask_q;
	logic       multicart_q;

	// controller state
	logic [8:0] rom_bank_q;
	logic [3:0] ram_bank_q;
	logic       ram_en_q;
	logic       mode_q;
	logic [8:0] hi_bank_q;
	logic [5:0] lo_bank_q;
	logic [3:0] ram_map_q;

	// pipeline
	logic               wr_valid_s1;
	cbc_pkg::wr_beat_t  wr_beat_s1;
	logic               map_valid_q;
	cbc_pkg::map_beat_t map_beat_q;

	logic wr_accept;
	logic out_ready;
	logic adv;
	logic cfg_wr;
	cbc_pkg::reg_idx_e cfg_idx;

	// next-state
	logic [8:0] rom_bank_n;
	logic [3:0] ram_bank_n;
	logic       ram_en_n;
	logic       mode_n;
	logic [8:0] hi_bank_n;
	logic [5:0] lo_bank_n;
	logic [3:0] ram_map_n;

	cbc_pkg::kind_e kind;
	cbc_pkg::area_e area;
	logic [7:0]     data;
	logic           bit8;
	logic [8:0]     rom_mask;
	logic [5:0]     remap;

	// handshake
	assign out_ready = !map_valid_q || !map_stall;
	assign adv       = wr_valid_s1 && out_ready;
	assign wr_stall  = wr_valid_s1 && !out_ready;
	assign wr_accept = wr_valid && !wr_stall;
	assign map_valid = map_valid_q;
	assign map_beat  = map_beat_q;

	// APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cbc_pkg::reg_idx_e'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			cbc_pkg::REG_HEADER_TYPE:    prdata = {24'd0, header_type_q};
			cbc_pkg::REG_ROM_BANK_MASK:  prdata = {23'd0, rom_bank_mask_q};
			cbc_pkg::REG_RAM_BANK_MASK:  prdata = {28'd0, ram_bank_mask_q};
			cbc_pkg::REG_MULTICART_MODE: prdata = {31'd0, multicart_q};
			default:                     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_type_q   <= 8'd0;
			rom_bank_mask_q <= 9'd1;
			ram_bank_mask_q <= 4'hF;
			multicart_q     <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cbc_pkg::REG_HEADER_TYPE:    header_type_q   <= pwdata[7:0];
				cbc_pkg::REG_ROM_BANK_MASK:  rom_bank_mask_q <= pwdata[8:0];
				cbc_pkg::REG_RAM_BANK_MASK:  ram_bank_mask_q <= pwdata[3:0];
				cbc_pkg::REG_MULTICART_MODE: multicart_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// decode of the registered beat
	assign kind     = cbc_pkg::kind_lookup(5'(header_type_q[4:0] + 5'd1));
	assign area     = cbc_pkg::area_e'(wr_beat_s1.write_addr[14:13]);
	assign bit8     = wr_beat_s1.write_addr[8];
	assign data     = wr_beat_s1.write_data;
	assign rom_mask = rom_bank_mask_q & RomMaskLimit;

	// register update and mapping
	always_comb begin
		rom_bank_n = rom_bank_q;
		ram_bank_n = ram_bank_q;
		ram_en_n   = ram_en_q;
		mode_n     = mode_q;
		hi_bank_n  = hi_bank_q;
		lo_bank_n  = lo_bank_q;
		ram_map_n  = ram_map_q;
		remap      = cbc_pkg::multi_remap(rom_bank_q);
		case (area)
			cbc_pkg::AREA_RAM_EN: begin
				if (!(kind == cbc_pkg::KIND_MBC2 && bit8)) begin
					ram_en_n  = (data[3:0] == 4'hA);
					ram_map_n = ram_bank_q & ram_bank_mask_q;
				end
			end
			cbc_pkg::AREA_ROM_BANK: begin
				if (!wr_beat_s1.write_addr[12] && kind == cbc_pkg::KIND_MBC5) begin
					rom_bank_n = {rom_bank_q[8], data};
					hi_bank_n  = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
				end else if (kind == cbc_pkg::KIND_MBC1) begin
					if (mode_q && !multicart_q)
						rom_bank_n = {4'd0, data[4:0]};
					else
						rom_bank_n = {2'd0, rom_bank_q[6:5], data[4:0]};
					remap = cbc_pkg::multi_remap(rom_bank_n);
					if (mode_q && multicart_q)
						hi_bank_n = cbc_pkg::fix_zero_bank({3'd0, remap}, kind);
					else
						hi_bank_n = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
				end else if (kind == cbc_pkg::KIND_MBC2) begin
					if (bit8) begin
						rom_bank_n = {5'd0, data[3:0]};
						hi_bank_n  = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
					end
				end else if (kind == cbc_pkg::KIND_MBC3) begin
					rom_bank_n = {2'd0, data[6:0]};
					hi_bank_n  = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
				end else if (kind == cbc_pkg::KIND_MBC5) begin
					rom_bank_n = {data[0], rom_bank_q[7:0]};
					hi_bank_n  = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
				end
			end
			cbc_pkg::AREA_RAM_BANK: begin
				if (kind == cbc_pkg::KIND_MBC1) begin
					if (mode_q && !multicart_q) begin
						ram_bank_n = {2'd0, data[1:0]};
						ram_map_n  = ram_bank_n & ram_bank_mask_q;
					end else begin
						rom_bank_n = {2'd0, data[1:0], rom_bank_q[4:0]};
						remap      = cbc_pkg::multi_remap(rom_bank_n);
						if (mode_q) begin
							// multicart: upper bits select the 16-bank game
							lo_bank_n = {remap[5:4], 4'd0};
							hi_bank_n = cbc_pkg::fix_zero_bank({3'd0, remap}, kind);
						end else begin
							hi_bank_n = cbc_pkg::fix_zero_bank(rom_bank_n & rom_mask, kind);
						end
					end
				end else if (kind == cbc_pkg::KIND_MBC3) begin
					ram_bank_n = {2'd0, data[1:0]};
					ram_map_n  = ram_bank_n & ram_bank_mask_q;
				end else if (kind == cbc_pkg::KIND_MBC5) begin
					ram_bank_n = data[3:0];
					ram_map_n  = ram_bank_n & ram_bank_mask_q;
				end
			end
			cbc_pkg::AREA_MODE: begin
				if (kind == cbc_pkg::KIND_MBC1) begin
					mode_n = data[0];
					if (multicart_q) begin
						if (mode_n) begin
							lo_bank_n = {remap[5:4], 4'd0};
							hi_bank_n = cbc_pkg::fix_zero_bank({3'd0, remap}, kind);
						end else begin
							lo_bank_n = 6'd0;
							hi_bank_n = cbc_pkg::fix_zero_bank(rom_bank_q & rom_mask, kind);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
		end else if (wr_accept) begin
			wr_valid_s1 <= 1'b1;
		end else if (adv) begin
			wr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_accept) begin
			wr_beat_s1 <= wr_beat;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 9'd1;
			ram_bank_q <= 4'd0;
			ram_en_q   <= 1'b0;
			mode_q     <= 1'b0;
			hi_bank_q  <= 9'd1;
			lo_bank_q  <= 6'd0;
			ram_map_q  <= 4'd0;
		end else if (adv) begin
			rom_bank_q <= rom_bank_n;
			ram_bank_q <= ram_bank_n;
			ram_en_q   <= ram_en_n;
			mode_q     <= mode_n;
			hi_bank_q  <= hi_bank_n;
			lo_bank_q  <= lo_bank_n;
			ram_map_q  <= ram_map_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= 1'b0;
		end else if (adv) begin
			map_valid_q <= 1'b1;
		end else if (!map_stall) begin
			map_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			map_beat_q.low_rom_bank  <= lo_bank_n;
			map_beat_q.high_rom_bank <= hi_bank_n;
			map_beat_q.ram_bank_sel  <= ram_map_n;
			map_beat_q.ram_on        <= ram_en_n;
		end
	end

endmodule

[rtl/cbc_checker.sv]
// ---------------------------------------------------------------------------
// Cartridge bank controller port checker
// Watches the beat channels of the core; bound to the core below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cartridge_bank_controller_core_assert.svh"

module cbc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               wr_valid,
	input logic               wr_stall,
	input logic               map_valid,
	input logic               map_stall,
	input cbc_pkg::map_beat_t map_beat
);

	// a held mapping beat stays put
	`CBC_ASSERT_NXT(a_map_hold, clk, arst_n, map_valid && map_stall, map_valid && $stable(map_beat))

	// write side only stalls when the output beat is blocked
	`CBC_ASSERT_IMP(a_stall_cause, clk, arst_n, wr_stall, map_valid && map_stall)

	// lower window bank is a multiple of 16
	`CBC_ASSERT_IMP(a_low_bank_align, clk, arst_n, map_valid, map_beat.low_rom_bank[3:0] == 4'd0)

	// no input stall without an earlier write beat in flight
	`CBC_ASSERT_NXT(a_stall_needs_beat, clk, arst_n, !wr_valid && !wr_stall && !map_valid, !wr_stall)

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.wr_valid  (wr_valid),
	.wr_stall  (wr_stall),
	.map_valid (map_valid),
	.map_stall (map_stall),
	.map_beat  (map_beat)
);
